// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the bit-field register unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/core/bfru_pkg.sv
// ---------------------------------------------------------------------------
// bfru_pkg
// Operation codes, payload types and rotate helpers for the bit-field unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfru_pkg;

   // Operation codes
   localparam logic [2:0] OP_TST  = 3'd0;
   localparam logic [2:0] OP_CHG  = 3'd1;
   localparam logic [2:0] OP_CLR  = 3'd2;
   localparam logic [2:0] OP_SET  = 3'd3;
   localparam logic [2:0] OP_INS  = 3'd4;
   localparam logic [2:0] OP_EXTU = 3'd5;
   localparam logic [2:0] OP_EXTS = 3'd6;
   localparam logic [2:0] OP_FFO  = 3'd7;

   localparam int unsigned WORD_W = 32;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] field_offset;
      logic [4:0]         field_width;
      logic [31:0]        target_value;
      logic [31:0]        source_value;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] target_out;
      logic        target_write;
      logic [31:0] dest_out;
      logic        dest_write;
      logic        flag_n;
      logic        flag_z;
   } rsp_payload_type;

   // Rotate right by 0..31
   function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [4:0] s);
      logic [5:0] back;
      back = 6'd32 - {1'b0, s};
      return (x >> s) | (x << back);
   endfunction

   // Rotate left by 0..31
   function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] s);
      logic [5:0] back;
      back = 6'd32 - {1'b0, s};
      return (x << s) | (x >> back);
   endfunction

   // Ones in the low w bits, w in 1..32
   function automatic logic [31:0] low_ones(input logic [5:0] w);
      logic [31:0] r;
      if (w[5]) begin
         r = '1;
      end else begin
         r = (32'd1 << w[4:0]) - 32'd1;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/bfru_lzc.sv
// ---------------------------------------------------------------------------
// bfru_lzc
// Leading zero count of a 32-bit word, 32 when the word is all zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfru_lzc (
   input  logic [31:0] bits,
   output logic [5:0]  count
);
   import bfru_pkg::*;

   logic [3:0]      byte_zero;
   logic [3:0][2:0] byte_lz;

   // Count within each byte
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         byte_zero[b] = (bits[b*8 +: 8] == 8'd0);
         byte_lz[b]   = 3'd0;
         for (int i = 0; i < 8; i++) begin
            if (bits[b*8 + i]) begin
               byte_lz[b] = 3'(7 - i);
            end
         end
      end
   end

   // Pick the first byte that holds a one
   always_comb begin
      if (!byte_zero[3]) begin
         count = {3'd0, byte_lz[3]};
      end else if (!byte_zero[2]) begin
         count = {3'd1, byte_lz[2]};
      end else if (!byte_zero[1]) begin
         count = {3'd2, byte_lz[1]};
      end else if (!byte_zero[0]) begin
         count = {3'd3, byte_lz[0]};
      end else begin
         count = 6'(WORD_W);
      end
   end

endmodule

// File: rtl/core/bitfield_register_unit.sv
// ---------------------------------------------------------------------------
// bitfield_register_unit
// 68020-style bit-field operations on a 32-bit data register, pipelined.
// ---------------------------------------------------------------------------
//  channel | ports                        | direction | payload
//  --------+------------------------------+-----------+------------------
//  request | req_valid req_ready req_data | in        | req_payload_type
//  result  | rsp_valid rsp_ready rsp_data | out       | rsp_payload_type
//
//  Five register stages: input capture, mask and rotate, field operation,
//  leading zero count, offset add into the output register. One transfer is
//  taken per cycle when the result side keeps up. Each stage takes a new
//  item when it is empty or its successor moves on, so a stall holds every
//  item in place and bubbles close up. Synchronous active-high reset clears
//  the stage valid bits only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitfield_register_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bfru_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bfru_pkg::rsp_payload_type rsp_data
);
   import bfru_pkg::*;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] full_off;
      logic [4:0]  width;
      logic [31:0] tgt;
      logic [31:0] src;
      logic [31:0] mask;
      logic [31:0] low_mask;
      logic [31:0] sign_bit;
      logic [31:0] rsrc;
      logic [31:0] just;
      logic [31:0] hi_mask;
   } s2_type;

   typedef struct packed {
      logic        is_ffo;
      logic [31:0] full_off;
      logic [5:0]  width6;
      logic [31:0] ffo_bits;
      rsp_payload_type rsp;
   } s3_type;

   typedef struct packed {
      logic        is_ffo;
      logic [31:0] full_off;
      logic [5:0]  lead;
      rsp_payload_type rsp;
   } s4_type;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   req_payload_type s1_ff;
   s2_type          s2_in, s2_ff;
   s3_type          s3_in, s3_ff;
   s4_type          s4_in, s4_ff;
   rsp_payload_type s5_in, s5_ff;
   logic [5:0]      lzc_count;

   // Stage advance: take a new item when empty or when the next stage moves
   assign adv5 = !s5_valid_ff || rsp_ready;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_ready = adv1;
   assign rsp_valid = s5_valid_ff;
   assign rsp_data  = s5_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (adv5) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Payload registers, held while stalled
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= req_data;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
      if (adv4) begin
         s4_ff <= s4_in;
      end
      if (adv5) begin
         s5_ff <= s5_in;
      end
   end

   // Stage 2: build the masks and rotate the operands
   always_comb begin
      logic [4:0] off;
      logic [4:0] extent;
      logic [5:0] width6;
      off    = s1_ff.field_offset[4:0];
      extent = off + s1_ff.field_width;
      width6 = {(s1_ff.field_width == 5'd0), s1_ff.field_width};

      s2_in.op        = s1_ff.req_type;
      s2_in.full_off  = s1_ff.field_offset;
      s2_in.width     = s1_ff.field_width;
      s2_in.tgt       = s1_ff.target_value;
      s2_in.src       = s1_ff.source_value;
      s2_in.low_mask  = low_ones(width6);
      s2_in.sign_bit  = 32'd1 << (s1_ff.field_width - 5'd1);
      s2_in.mask      = rot_right(low_ones(width6), extent);
      s2_in.rsrc      = rot_right(s1_ff.source_value, extent);
      s2_in.just      = rot_left(s1_ff.target_value, off);
      s2_in.hi_mask   = rot_right(low_ones(width6), s1_ff.field_width);
   end

   // Stage 3: apply the operation to the field
   always_comb begin
      logic [31:0] field;
      field = rot_left(s2_ff.just, s2_ff.width) & s2_ff.low_mask;

      s3_in.is_ffo   = (s2_ff.op == OP_FFO);
      s3_in.full_off = s2_ff.full_off;
      s3_in.width6   = {(s2_ff.width == 5'd0), s2_ff.width};
      s3_in.ffo_bits = s2_ff.just & s2_ff.hi_mask;

      s3_in.rsp.target_out   = s2_ff.tgt;
      s3_in.rsp.target_write = 1'b0;
      s3_in.rsp.dest_out     = '0;
      s3_in.rsp.dest_write   = 1'b0;
      s3_in.rsp.flag_n       = s2_ff.just[31];
      s3_in.rsp.flag_z       = ((s2_ff.tgt & s2_ff.mask) == 32'd0);

      case (s2_ff.op)
         OP_CHG: begin
            s3_in.rsp.target_out   = s2_ff.tgt ^ s2_ff.mask;
            s3_in.rsp.target_write = 1'b1;
         end
         OP_CLR: begin
            s3_in.rsp.target_out   = s2_ff.tgt & ~s2_ff.mask;
            s3_in.rsp.target_write = 1'b1;
         end
         OP_SET: begin
            s3_in.rsp.target_out   = s2_ff.tgt | s2_ff.mask;
            s3_in.rsp.target_write = 1'b1;
         end
         OP_INS: begin
            s3_in.rsp.target_out   = (s2_ff.tgt & ~s2_ff.mask) | (s2_ff.rsrc & s2_ff.mask);
            s3_in.rsp.target_write = 1'b1;
            s3_in.rsp.flag_n       = |(s2_ff.src & s2_ff.sign_bit);
            s3_in.rsp.flag_z       = ((s2_ff.src & s2_ff.low_mask) == 32'd0);
         end
         OP_EXTU: begin
            s3_in.rsp.dest_out   = field;
            s3_in.rsp.dest_write = 1'b1;
         end
         OP_EXTS: begin
            s3_in.rsp.dest_out   = (|(field & s2_ff.sign_bit)) ? (field | ~s2_ff.low_mask)
                                                               : field;
            s3_in.rsp.dest_write = 1'b1;
         end
         OP_FFO: begin
            s3_in.rsp.dest_write = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Stage 4: count leading zeros of the left-justified field
   bfru_lzc u_lzc (
      .bits  (s3_ff.ffo_bits),
      .count (lzc_count)
   );

   always_comb begin
      s4_in.is_ffo   = s3_ff.is_ffo;
      s4_in.full_off = s3_ff.full_off;
      s4_in.rsp      = s3_ff.rsp;
      s4_in.lead     = (s3_ff.ffo_bits == 32'd0) ? s3_ff.width6 : lzc_count;
   end

   // Stage 5: add the full offset for find-first-one
   always_comb begin
      s5_in = s4_ff.rsp;
      if (s4_ff.is_ffo) begin
         s5_in.dest_out = s4_ff.full_off + {26'd0, s4_ff.lead};
      end
   end

   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")
   `ASSERT_PROP(a_accept_enters, clock, reset, req_valid && req_ready |=> s1_valid_ff,
                "accepted transfer lost at entry")
   `ASSERT_PROP(a_stall_holds, clock, reset, s4_valid_ff && !adv5 |=> s4_valid_ff && s5_valid_ff,
                "stalled item dropped")
   `ASSERT_PROP(a_one_write, clock, reset,
                rsp_valid |-> !(rsp_data.target_write && rsp_data.dest_write),
                "both write enables set")
   `ASSERT_PROP(a_dest_zero, clock, reset,
                rsp_valid && !rsp_data.dest_write |-> rsp_data.dest_out == 32'd0,
                "destination value without write")

endmodule
